/* hw/rtl/ocp_pkg.sv */
// shared types, constants and arithmetic helpers for the omni camera point projection core
package ocp_pkg;

	// coefficient slots and pipeline step counts
	localparam int MAX_TERMS    = 16;
	localparam int SQRT_STEPS   = 32;
	localparam int ATAN_STEPS   = 31;
	localparam int PIPE_DEPTH   = 2 + SQRT_STEPS + ATAN_STEPS + 2 * MAX_TERMS + 5;

	// command codes
	localparam logic CMD_PROJECT = 1'b0;
	localparam logic CMD_WRITE   = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_AFFINE_C   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AFFINE_D   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AFFINE_E   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_U   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_V   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT = 3'd5;

	// input beat
	typedef struct packed {
		logic               command;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [3:0]         coef_index;
		logic signed [47:0] coef_value;
	} in_item_t;

	// result beat
	typedef struct packed {
		logic signed [31:0] image_u;
		logic signed [31:0] image_v;
		logic               on_axis;
	} out_item_t;

	// control that travels with every pipeline stage
	typedef struct packed {
		logic               valid;
		logic               write;
		logic               on_axis;
		logic [3:0]         coef_index;
		logic signed [47:0] coef_value;
	} side_t;

	// arctangent table, round(atan(2^-i) * 2^30)
	function automatic logic signed [31:0] atan_angle(input logic [4:0] i);
		logic signed [31:0] a;
		case (i)
			5'd0: a = 32'sd843314857;
			5'd1: a = 32'sd497837829;
			5'd2: a = 32'sd263043837;
			5'd3: a = 32'sd133525159;
			5'd4: a = 32'sd67021687;
			5'd5: a = 32'sd33543516;
			5'd6: a = 32'sd16775851;
			5'd7: a = 32'sd8388437;
			5'd8: a = 32'sd4194283;
			5'd9: a = 32'sd2097149;
			default: a = 32'sd1 <<< (5'd30 - i);
		endcase
		return a;
	endfunction

	// full product from the two registered partial products
	function automatic logic signed [79:0] mul_join(input logic signed [64:0] pp_lo,
		input logic signed [63:0] pp_hi);
		return $signed({pp_hi, 16'h0000}) + 80'(pp_lo);
	endfunction

	// saturate to 48 bits signed
	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		logic signed [47:0] r;
		if (v > 64'sd140737488355327) begin
			r = 48'sh7FFF_FFFF_FFFF;
		end else if (v < -64'sd140737488355328) begin
			r = 48'sh8000_0000_0000;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

	// saturate to 32 bits signed
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/ocp_mul.sv */
// 48 x 32 signed multiply split into two registered 48 x 16 partial products
module ocp_mul (
	input  logic               clk,
	input  logic signed [47:0] a,
	input  logic signed [31:0] b,
	output logic signed [64:0] pp_lo,
	output logic signed [63:0] pp_hi
);

	// low half of b is unsigned, high half carries the sign
	always_ff @(posedge clk) begin
		pp_lo <= a * $signed({1'b0, b[15:0]});
		pp_hi <= a * $signed(b[31:16]);
	end

endmodule

/* hw/rtl/omni_camera_point_projection_core.sv */
// top level of the omni camera point projection core
//
// Usage: an item is taken at a rising edge with start high and busy low. A project
// item (command 0) carries a camera point; a write item (command 1) loads one
// polynomial coefficient and gives no result. Items may be issued in every cycle:
// the core is a straight pipeline and takes one item per clock.
// A project item returns one result beat on result, marked by done for exactly one
// cycle, once the item has passed every pipeline stage. Results leave in issue
// order. The receiver cannot stall the core, so the pipeline never holds.
// The depth is set by the squares and their sum, the square root (32 steps), the
// arctangent and the two ratio divides (31 steps side by side), the Horner chain
// (two stages per coefficient slot) and five stages of scaling and affine mapping.
// A coefficient write flows down the pipeline and lands in its slot's register
// when it passes that slot's Horner stage, so it orders correctly against points.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data; the
// user must write them only while no point is in flight; the core does not enforce this.
// cfg_ready is always high. Reset clears all valid bits and loads the register
// defaults; busy comes from a register that reset sets and every clock edge out of
// reset clears. Coefficients are undefined until written.
module omni_camera_point_projection_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  ocp_pkg::in_item_t                 item,
	output logic                              done,
	output ocp_pkg::out_item_t                result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ocp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data
);

	localparam int NT = ocp_pkg::MAX_TERMS;
	localparam int NS = ocp_pkg::SQRT_STEPS;
	localparam int NA = ocp_pkg::ATAN_STEPS;

	// busy only around reset
	logic busy_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end
	assign busy = busy_q;
	assign cfg_ready = 1'b1;

	// configuration registers
	logic signed [31:0] affine_c_q, affine_d_q, affine_e_q, center_u_q, center_v_q;
	logic [4:0]         term_count_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			affine_c_q   <= 32'sd16777216;
			affine_d_q   <= '0;
			affine_e_q   <= '0;
			center_u_q   <= '0;
			center_v_q   <= '0;
			term_count_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ocp_pkg::CFG_AFFINE_C:   affine_c_q   <= cfg_data;
				ocp_pkg::CFG_AFFINE_D:   affine_d_q   <= cfg_data;
				ocp_pkg::CFG_AFFINE_E:   affine_e_q   <= cfg_data;
				ocp_pkg::CFG_CENTER_U:   center_u_q   <= cfg_data;
				ocp_pkg::CFG_CENTER_V:   center_v_q   <= cfg_data;
				ocp_pkg::CFG_TERM_COUNT: term_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// clamped term count and index of the leading coefficient
	logic [4:0] term_n, term_top;
	always_comb begin
		if (term_count_q == 5'd0) begin
			term_n = 5'd1;
		end else if (term_count_q > 5'(NT)) begin
			term_n = 5'(NT);
		end else begin
			term_n = term_count_q;
		end
		term_top = term_n - 5'd1;
	end

	// stage 1: squares
	ocp_pkg::side_t     side_s1;
	logic signed [31:0] x_s1, y_s1, z_s1;
	logic signed [63:0] xx_s1, yy_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1.valid      <= start && !busy;
			side_s1.write      <= item.command == ocp_pkg::CMD_WRITE;
			side_s1.on_axis    <= 1'b0;
			side_s1.coef_index <= item.coef_index;
			side_s1.coef_value <= item.coef_value;
		end
	end
	always_ff @(posedge clk) begin
		x_s1  <= item.point_x;
		y_s1  <= item.point_y;
		z_s1  <= item.point_z;
		xx_s1 <= item.point_x * item.point_x;
		yy_s1 <= item.point_y * item.point_y;
	end

	// stage 2: sum of squares
	ocp_pkg::side_t     side_s2;
	logic signed [31:0] x_s2, y_s2, z_s2;
	logic [63:0]        sum_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2 <= side_s1;
		end
	end
	always_ff @(posedge clk) begin
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		z_s2   <= z_s1;
		sum_s2 <= $unsigned(xx_s1) + $unsigned(yy_s1);
	end

	// square root, one result bit per stage
	ocp_pkg::side_t     sq_side_s [0:NS];
	logic signed [31:0] sq_x_s    [0:NS];
	logic signed [31:0] sq_y_s    [0:NS];
	logic signed [31:0] sq_z_s    [0:NS];
	logic [63:0]        sq_v_s    [0:NS];
	logic [63:0]        sq_r_s    [0:NS];
	assign sq_side_s[0] = side_s2;
	assign sq_x_s[0]    = x_s2;
	assign sq_y_s[0]    = y_s2;
	assign sq_z_s[0]    = z_s2;
	assign sq_v_s[0]    = sum_s2;
	assign sq_r_s[0]    = '0;

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial, v_nx, r_nx;
		always_comb begin
			trial = sq_r_s[k] + SQ_BIT;
			if (sq_v_s[k] >= trial) begin
				v_nx = sq_v_s[k] - trial;
				r_nx = (sq_r_s[k] >> 1) + SQ_BIT;
			end else begin
				v_nx = sq_v_s[k];
				r_nx = sq_r_s[k] >> 1;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_side_s[k+1] <= '0;
			end else begin
				sq_side_s[k+1] <= sq_side_s[k];
			end
		end
		always_ff @(posedge clk) begin
			sq_x_s[k+1] <= sq_x_s[k];
			sq_y_s[k+1] <= sq_y_s[k];
			sq_z_s[k+1] <= sq_z_s[k];
			sq_v_s[k+1] <= v_nx;
			sq_r_s[k+1] <= r_nx;
		end
	end

	// arctangent by cordic and the two ratio divides, side by side
	logic [31:0] norm;
	assign norm = sq_r_s[NS][31:0];

	ocp_pkg::side_t     at_side_s [0:NA];
	logic signed [51:0] at_x_s    [0:NA];
	logic signed [51:0] at_y_s    [0:NA];
	logic signed [31:0] at_a_s    [0:NA];
	logic [31:0]        at_n_s    [0:NA];
	logic [63:0]        dx_rem_s  [0:NA];
	logic [63:0]        dy_rem_s  [0:NA];
	logic [30:0]        dx_q_s    [0:NA];
	logic [30:0]        dy_q_s    [0:NA];
	logic               dx_neg_s  [0:NA];
	logic               dy_neg_s  [0:NA];

	logic [31:0] abs_x, abs_y;
	always_comb begin
		abs_x = sq_x_s[NS][31] ? 32'(-sq_x_s[NS]) : sq_x_s[NS];
		abs_y = sq_y_s[NS][31] ? 32'(-sq_y_s[NS]) : sq_y_s[NS];
		at_side_s[0]         = sq_side_s[NS];
		at_side_s[0].on_axis = norm == 32'd0;
	end
	assign at_x_s[0]   = $signed({4'h0, norm, 16'h0000});
	assign at_y_s[0]   = $signed({{4{sq_z_s[NS][31]}}, sq_z_s[NS], 16'h0000});
	assign at_a_s[0]   = '0;
	assign at_n_s[0]   = norm;
	assign dx_rem_s[0] = {2'b00, abs_x, 30'h0};
	assign dy_rem_s[0] = {2'b00, abs_y, 30'h0};
	assign dx_q_s[0]   = '0;
	assign dy_q_s[0]   = '0;
	assign dx_neg_s[0] = sq_x_s[NS][31];
	assign dy_neg_s[0] = sq_y_s[NS][31];

	for (genvar j = 0; j < NA; j++) begin : g_atan
		localparam int QB = NA - 1 - j;
		logic signed [51:0] xs, ys, x_nx, y_nx;
		logic signed [31:0] a_nx;
		logic [63:0]        dv, rx_nx, ry_nx;
		logic               tx, ty;
		always_comb begin
			xs = at_x_s[j] >>> j;
			ys = at_y_s[j] >>> j;
			if (!at_y_s[j][51]) begin
				x_nx = at_x_s[j] + ys;
				y_nx = at_y_s[j] - xs;
				a_nx = at_a_s[j] + ocp_pkg::atan_angle(5'(j));
			end else begin
				x_nx = at_x_s[j] - ys;
				y_nx = at_y_s[j] + xs;
				a_nx = at_a_s[j] - ocp_pkg::atan_angle(5'(j));
			end
			dv    = 64'(at_n_s[j]) << QB;
			tx    = dx_rem_s[j] >= dv;
			ty    = dy_rem_s[j] >= dv;
			rx_nx = tx ? dx_rem_s[j] - dv : dx_rem_s[j];
			ry_nx = ty ? dy_rem_s[j] - dv : dy_rem_s[j];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				at_side_s[j+1] <= '0;
			end else begin
				at_side_s[j+1] <= at_side_s[j];
			end
		end
		always_ff @(posedge clk) begin
			at_x_s[j+1]   <= x_nx;
			at_y_s[j+1]   <= y_nx;
			at_a_s[j+1]   <= a_nx;
			at_n_s[j+1]   <= at_n_s[j];
			dx_rem_s[j+1] <= rx_nx;
			dy_rem_s[j+1] <= ry_nx;
			dx_q_s[j+1]   <= {dx_q_s[j][29:0], tx};
			dy_q_s[j+1]   <= {dy_q_s[j][29:0], ty};
			dx_neg_s[j+1] <= dx_neg_s[j];
			dy_neg_s[j+1] <= dy_neg_s[j];
		end
	end

	// horner chain, two stages per coefficient slot, highest slot first
	ocp_pkg::side_t     hr_side_s  [0:NT];
	logic signed [47:0] hr_rho_s   [0:NT];
	logic signed [31:0] hr_theta_s [0:NT];
	logic signed [31:0] hr_rx_s    [0:NT];
	logic signed [31:0] hr_ry_s    [0:NT];
	assign hr_side_s[0]  = at_side_s[NA];
	assign hr_rho_s[0]   = '0;
	assign hr_theta_s[0] = at_a_s[NA];
	assign hr_rx_s[0]    = dx_neg_s[NA] ? -$signed({1'b0, dx_q_s[NA]})
		: $signed({1'b0, dx_q_s[NA]});
	assign hr_ry_s[0]    = dy_neg_s[NA] ? -$signed({1'b0, dy_q_s[NA]})
		: $signed({1'b0, dy_q_s[NA]});

	for (genvar p = 0; p < NT; p++) begin : g_horner
		localparam logic [4:0] IDX = 5'(NT - 1 - p);
		ocp_pkg::side_t     side_a;
		logic signed [47:0] rho_a, coef_q, rho_nx;
		logic signed [31:0] theta_a, rx_a, ry_a;
		logic signed [64:0] pp_lo;
		logic signed [63:0] pp_hi;
		logic signed [79:0] prod;
		logic signed [50:0] acc;

		// rho times theta
		ocp_mul u_mul (
			.clk   (clk),
			.a     (hr_rho_s[p]),
			.b     (hr_theta_s[p]),
			.pp_lo (pp_lo),
			.pp_hi (pp_hi)
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_a <= '0;
			end else begin
				side_a <= hr_side_s[p];
			end
		end
		always_ff @(posedge clk) begin
			rho_a   <= hr_rho_s[p];
			theta_a <= hr_theta_s[p];
			rx_a    <= hr_rx_s[p];
			ry_a    <= hr_ry_s[p];
		end

		// coefficient slot, loaded by a write beat passing through
		always_ff @(posedge clk) begin
			if (side_a.valid && side_a.write && side_a.coef_index == IDX[3:0]) begin
				coef_q <= side_a.coef_value;
			end
		end

		// add this slot's coefficient, load it as the leading term, or pass rho through for unused slots
		always_comb begin
			prod = ocp_pkg::mul_join(pp_lo, pp_hi);
			acc  = 51'($signed(prod[79:30])) + 51'(coef_q);
			if (IDX == term_top) begin
				rho_nx = coef_q;
			end else if (IDX < term_top) begin
				rho_nx = ocp_pkg::sat48(64'(acc));
			end else begin
				rho_nx = rho_a;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hr_side_s[p+1] <= '0;
			end else begin
				hr_side_s[p+1] <= side_a;
			end
		end
		always_ff @(posedge clk) begin
			hr_rho_s[p+1]   <= rho_nx;
			hr_theta_s[p+1] <= theta_a;
			hr_rx_s[p+1]    <= rx_a;
			hr_ry_s[p+1]    <= ry_a;
		end
	end

	// scale the ratios by rho
	ocp_pkg::side_t     side_xa_s;
	logic signed [64:0] xpl, ypl;
	logic signed [63:0] xph, yph;
	ocp_mul u_mul_xp (
		.clk   (clk),
		.a     (hr_rho_s[NT]),
		.b     (hr_rx_s[NT]),
		.pp_lo (xpl),
		.pp_hi (xph)
	);
	ocp_mul u_mul_yp (
		.clk   (clk),
		.a     (hr_rho_s[NT]),
		.b     (hr_ry_s[NT]),
		.pp_lo (ypl),
		.pp_hi (yph)
	);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_xa_s <= '0;
		end else begin
			side_xa_s <= hr_side_s[NT];
		end
	end

	ocp_pkg::side_t     side_xb_s;
	logic signed [47:0] xp_xb_s, yp_xb_s;
	logic signed [79:0] xp_prod, yp_prod;
	assign xp_prod = ocp_pkg::mul_join(xpl, xph);
	assign yp_prod = ocp_pkg::mul_join(ypl, yph);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_xb_s <= '0;
		end else begin
			side_xb_s <= side_xa_s;
		end
	end
	always_ff @(posedge clk) begin
		xp_xb_s <= ocp_pkg::sat48(64'($signed(xp_prod[79:30])));
		yp_xb_s <= ocp_pkg::sat48(64'($signed(yp_prod[79:30])));
	end

	// affine products
	ocp_pkg::side_t     side_ua_s;
	logic signed [47:0] yp_ua_s;
	logic signed [64:0] cl, dl, el;
	logic signed [63:0] ch, dh, eh;
	ocp_mul u_mul_c (.clk(clk), .a(xp_xb_s), .b(affine_c_q), .pp_lo(cl), .pp_hi(ch));
	ocp_mul u_mul_d (.clk(clk), .a(yp_xb_s), .b(affine_d_q), .pp_lo(dl), .pp_hi(dh));
	ocp_mul u_mul_e (.clk(clk), .a(xp_xb_s), .b(affine_e_q), .pp_lo(el), .pp_hi(eh));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_ua_s <= '0;
		end else begin
			side_ua_s <= side_xb_s;
		end
	end
	always_ff @(posedge clk) begin
		yp_ua_s <= yp_xb_s;
	end

	// join the products and drop the fraction
	ocp_pkg::side_t     side_ub_s;
	logic signed [47:0] yp_ub_s;
	logic signed [55:0] pc_ub_s, pd_ub_s, pe_ub_s;
	logic signed [79:0] c_prod, d_prod, e_prod;
	assign c_prod = ocp_pkg::mul_join(cl, ch);
	assign d_prod = ocp_pkg::mul_join(dl, dh);
	assign e_prod = ocp_pkg::mul_join(el, eh);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_ub_s <= '0;
		end else begin
			side_ub_s <= side_ua_s;
		end
	end
	always_ff @(posedge clk) begin
		yp_ub_s <= yp_ua_s;
		pc_ub_s <= c_prod[79:24];
		pd_ub_s <= d_prod[79:24];
		pe_ub_s <= e_prod[79:24];
	end

	// final sums, center offset, saturation and the result register
	logic signed [57:0] sum_u, sum_v;
	always_comb begin
		sum_u = 58'(pc_ub_s) + 58'(pd_ub_s) + 58'($signed({center_u_q, 8'h00}));
		sum_v = 58'(pe_ub_s) + 58'(yp_ub_s) + 58'($signed({center_v_q, 8'h00}));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= side_ub_s.valid && !side_ub_s.write;
		end
	end
	always_ff @(posedge clk) begin
		if (side_ub_s.on_axis) begin
			result.image_u <= center_u_q;
			result.image_v <= center_v_q;
			result.on_axis <= 1'b1;
		end else begin
			result.image_u <= ocp_pkg::sat32(64'($signed(sum_u[57:8])));
			result.image_v <= ocp_pkg::sat32(64'($signed(sum_v[57:8])));
			result.on_axis <= 1'b0;
		end
	end

	// every result comes from a project beat a fixed depth earlier
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && item.command == ocp_pkg::CMD_PROJECT,
			ocp_pkg::PIPE_DEPTH))
		else $error("result without matching project beat");

	// a project beat always produces its result
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy && item.command == ocp_pkg::CMD_PROJECT,
			ocp_pkg::PIPE_DEPTH) && $past(arst_n, ocp_pkg::PIPE_DEPTH) |-> done)
		else $error("project beat lost");

	// on-axis results return the center
	a_on_axis: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.on_axis |-> result.image_u == center_u_q
			&& result.image_v == center_v_q)
		else $error("on-axis result is not the center");

	// busy never returns once the core is out of reset
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy raised after reset");

endmodule

/* verif/omni_camera_point_projection_core_test.sv */
// self-checking testbench for the omni camera point projection core
`timescale 1ns / 1ps

module omni_camera_point_projection_core_test;

	localparam int LATENCY = 110;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	ocp_pkg::in_item_t item;
	logic done;
	ocp_pkg::out_item_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [ocp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	omni_camera_point_projection_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the core state
	logic signed [47:0] coef_mem [ocp_pkg::MAX_TERMS];
	logic signed [31:0] aff_c, aff_d, aff_e, ctr_u, ctr_v;
	logic [4:0] terms;

	ocp_pkg::in_item_t pending_items[$];
	ocp_pkg::out_item_t expected_pixels[$];
	int errors = 0;
	longint cycles = 0;
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic longint sat_f(input longint v, input int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	// floor(a*b / 2^s) split so the product stays in 64 bits
	function automatic longint mul_shr(input longint a, input longint b, input int s);
		longint bh, bl;
		bh = b >>> 16;
		bl = b - bh * 65536;
		return ((a * bl) >>> 16) + a * bh >>> (s - 16);
	endfunction

	function automatic longint int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint elevation(input longint z, input longint nrm);
		longint xv, yv, ang, xs, ys, tab;
		xv = nrm * 65536;
		yv = z * 65536;
		ang = 0;
		for (int i = 0; i < 31; i++) begin
			xs = xv >>> i;
			ys = yv >>> i;
			case (i)
				0: tab = 843314857;
				1: tab = 497837829;
				2: tab = 263043837;
				3: tab = 133525159;
				4: tab = 67021687;
				5: tab = 33543516;
				6: tab = 16775851;
				7: tab = 8388437;
				8: tab = 4194283;
				9: tab = 2097149;
				default: tab = longint'(1) <<< (30 - i);
			endcase
			if (yv >= 0) begin
				xv += ys; yv -= xs; ang += tab;
			end else begin
				xv -= ys; yv += xs; ang -= tab;
			end
		end
		return ang;
	endfunction

	function automatic void predict_pixel(input ocp_pkg::in_item_t it);
		longint x, y, z, nrm, th, rho, rx, ry, xp, yp, u, v;
		int n;
		ocp_pkg::out_item_t r;
		if (it.command == ocp_pkg::CMD_WRITE) begin
			coef_mem[it.coef_index] = it.coef_value;
			return;
		end
		x = it.point_x;
		y = it.point_y;
		z = it.point_z;
		nrm = int_sqrt(longint'(x * x) + longint'(y * y));
		if (nrm == 0) begin
			r.image_u = ctr_u;
			r.image_v = ctr_v;
			r.on_axis = 1'b1;
			expected_pixels.insert(expected_pixels.size(), r);
			return;
		end
		th = elevation(z, nrm);
		n = terms;
		if (n < 1) n = 1;
		if (n > ocp_pkg::MAX_TERMS) n = ocp_pkg::MAX_TERMS;
		rho = coef_mem[n - 1];
		for (int i = n - 2; i >= 0; i--)
			rho = sat_f(mul_shr(rho, th, 30) + longint'(coef_mem[i]), 48);
		rx = (x * 1073741824) / nrm;
		ry = (y * 1073741824) / nrm;
		xp = sat_f(mul_shr(rho, rx, 30), 48);
		yp = sat_f(mul_shr(rho, ry, 30), 48);
		u = mul_shr(xp, aff_c, 24) + mul_shr(yp, aff_d, 24) + longint'(ctr_u) * 256;
		v = mul_shr(xp, aff_e, 24) + yp + longint'(ctr_v) * 256;
		r.image_u = 32'(sat_f(u >>> 8, 32));
		r.image_v = 32'(sat_f(v >>> 8, 32));
		r.on_axis = 1'b0;
		expected_pixels.insert(expected_pixels.size(), r);
	endfunction

	// driver: one beat per accepted start
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
		end else begin
			if (start && !busy) begin
				predict_pixel(item);
				void'(pending_items.pop_front());
			end
			if (!(start && busy)) begin
				if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 10)) begin
					start <= 1'b1;
					item <= pending_items[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected result u=%0d v=%0d",
					result.image_u, result.image_v));
			end else begin
				ocp_pkg::out_item_t e;
				e = expected_pixels.pop_front();
				if (result.image_u !== e.image_u)
					report_mismatch($sformatf("image_u %0d want %0d", result.image_u, e.image_u));
				if (result.image_v !== e.image_v)
					report_mismatch($sformatf("image_v %0d want %0d", result.image_v, e.image_v));
				if (result.on_axis !== e.on_axis)
					report_mismatch($sformatf("on_axis %0b want %0b", result.on_axis, e.on_axis));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[omni_camera_point_projection_core] ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [ocp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ocp_pkg::CFG_AFFINE_C: aff_c = val;
			ocp_pkg::CFG_AFFINE_D: aff_d = val;
			ocp_pkg::CFG_AFFINE_E: aff_e = val;
			ocp_pkg::CFG_CENTER_U: ctr_u = val;
			ocp_pkg::CFG_CENTER_V: ctr_v = val;
			ocp_pkg::CFG_TERM_COUNT: terms = val[4:0];
			default: ;
		endcase
	endtask

	function automatic ocp_pkg::in_item_t coef_beat(input int idx,
		input logic signed [47:0] val);
		ocp_pkg::in_item_t it;
		it = '0;
		it.command = ocp_pkg::CMD_WRITE;
		it.point_x = $urandom;
		it.point_y = $urandom;
		it.point_z = $urandom;
		it.coef_index = 4'(idx);
		it.coef_value = val;
		return it;
	endfunction

	function automatic ocp_pkg::in_item_t point_beat(input logic [31:0] x,
		input logic [31:0] y, input logic [31:0] z);
		ocp_pkg::in_item_t it;
		it.command = ocp_pkg::CMD_PROJECT;
		it.point_x = x;
		it.point_y = y;
		it.point_z = z;
		it.coef_index = 4'($urandom);
		it.coef_value = 48'({$urandom, $urandom});
		return it;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000)) - 1000);
			2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 200000000)) - 100000000);
		endcase
	endfunction

	function automatic logic signed [47:0] rand_coef();
		case ($urandom_range(3))
			0: return 48'({$urandom, $urandom});
			1: return $urandom_range(1) ? 48'sh7FFF_FFFF_FFFF : 48'sh8000_0000_0000;
			default: return 48'($signed($urandom_range(0, 400000000)) - 200000000) <<< 4;
		endcase
	endfunction

	// wait until every beat is in and every result is out, then drain
	task automatic wait_drained();
		while (pending_items.size() != 0 || start) @(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// random phase: mostly projections, some coefficient rewrites
	task automatic random_phase(input int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 8)
				pending_items.insert(pending_items.size(),
					coef_beat($urandom_range(15), rand_coef()));
			else if ($urandom_range(99) < 5)
				pending_items.insert(pending_items.size(), point_beat(0, 0, rand_coord()));
			else
				pending_items.insert(pending_items.size(),
					point_beat(rand_coord(), rand_coord(), rand_coord()));
		end
		wait_drained();
	endtask

	initial begin
		quiet = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		aff_c = 32'sd16777216;
		aff_d = 0;
		aff_e = 0;
		ctr_u = 0;
		ctr_v = 0;
		terms = 5'd1;
		foreach (coef_mem[i]) coef_mem[i] = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: on-axis before any coefficient is needed, then load all slots, then extreme points and a slot 0 rewrite
		pending_items.insert(pending_items.size(), point_beat(0, 0, 32'h7FFF_FFFF));
		for (int i = 0; i < ocp_pkg::MAX_TERMS; i++)
			pending_items.insert(pending_items.size(),
				coef_beat(i, i == 0 ? 48'sd1 <<< 30 : rand_coef()));
		pending_items.insert(pending_items.size(),
			point_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		pending_items.insert(pending_items.size(),
			point_beat(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
		pending_items.insert(pending_items.size(), point_beat(32'h0001_0000, 0, 0));
		pending_items.insert(pending_items.size(),
			point_beat(0, 32'hFFFF_FFFF, 32'h0001_0000));
		pending_items.insert(pending_items.size(), point_beat(1, 0, 32'h8000_0000));
		pending_items.insert(pending_items.size(), point_beat(0, 0, 0));
		pending_items.insert(pending_items.size(), coef_beat(0, 48'sh7FFF_FFFF_FFFF));
		pending_items.insert(pending_items.size(),
			point_beat(32'h0010_0000, 32'hFFF0_0000, 32'h0008_0000));
		wait_drained();

		// several register settings, extremes included
		write_reg(ocp_pkg::CFG_TERM_COUNT, 32'd16);
		write_reg(ocp_pkg::CFG_CENTER_U, 32'h7FFF_FFFF);
		write_reg(ocp_pkg::CFG_CENTER_V, 32'h8000_0000);
		write_reg(ocp_pkg::CFG_AFFINE_D, 32'h7FFF_FFFF);
		write_reg(ocp_pkg::CFG_AFFINE_E, 32'h8000_0000);
		random_phase(300);

		write_reg(ocp_pkg::CFG_AFFINE_C, 32'h8000_0000);
		write_reg(ocp_pkg::CFG_AFFINE_D, 32'h0000_0000);
		write_reg(ocp_pkg::CFG_TERM_COUNT, 32'd0);
		random_phase(300);

		write_reg(ocp_pkg::CFG_TERM_COUNT, 32'd31);
		write_reg(ocp_pkg::CFG_AFFINE_C, 32'h7FFF_FFFF);
		write_reg(ocp_pkg::CFG_CENTER_U, 32'h0000_0000);
		write_reg(ocp_pkg::CFG_CENTER_V, 32'h0000_0000);
		quiet = 1'b1;
		random_phase(300);
		quiet = 1'b0;

		for (int p = 0; p < 3; p++) begin
			write_reg(ocp_pkg::CFG_AFFINE_C, $urandom);
			write_reg(ocp_pkg::CFG_AFFINE_D, $urandom);
			write_reg(ocp_pkg::CFG_AFFINE_E, $urandom);
			write_reg(ocp_pkg::CFG_CENTER_U, $urandom);
			write_reg(ocp_pkg::CFG_CENTER_V, $urandom);
			write_reg(ocp_pkg::CFG_TERM_COUNT, $urandom_range(1, 16));
			random_phase(300);
		end

		if (errors == 0) begin
			$display("[omni_camera_point_projection_core] OK");
		end else begin
			$display("[omni_camera_point_projection_core] ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/ocp_pkg.sv
hw/rtl/ocp_mul.sv
hw/rtl/omni_camera_point_projection_core.sv
verif/omni_camera_point_projection_core_test.sv
